// ===== rtl/prpz_pkg.sv =====
// Shared types, constants and micro-op table for the point rotate/project/z-buffer block.
package prpz_pkg;

	localparam int SCREEN_WIDTH    = 160;
	localparam int SCREEN_HEIGHT   = 44;
	localparam int BACKGROUND_CHAR = 32;
	localparam int RECIP_FRAC_BITS = 24;

	localparam int CELLS   = SCREEN_WIDTH * SCREEN_HEIGHT;
	localparam int CELL_W  = $clog2(CELLS);
	localparam int DEPTH_W = 24;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = {DEPTH_W{1'b1}};

	localparam int TRIG_W   = 16;
	localparam int SCALE_W  = 8;
	localparam int CAM_W    = 11;
	localparam int POS_W    = 16;
	localparam int GLYPH_W  = 8;
	localparam int STATUS_W = 2;
	localparam int PADDR_W  = 5;
	localparam int REG_W    = 3;

	localparam int FRAC_SHIFT = 14;
	localparam int CAM_SHIFT  = 18;
	localparam int ONE_Q14    = 1 << FRAC_SHIFT;

	// datapath widths
	localparam int M_W    = 20;
	localparam int ROT_W  = 40;
	localparam int ACC_W  = 48;
	localparam int OPA_W  = 40;
	localparam int OPB_W  = 18;
	localparam int PROD_W = OPA_W + OPB_W;

	// divider
	localparam int MAX_DIM  = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int PQ_BITS  = $clog2(MAX_DIM);
	localparam int DIV_QMAX = (RECIP_FRAC_BITS > PQ_BITS) ? RECIP_FRAC_BITS : PQ_BITS;
	localparam int DIV_NW   = $clog2(DIV_QMAX + 1);
	localparam int DIV_DW   = 64;
	localparam int DVS_W    = ROT_W - 1;
	localparam logic [DIV_DW-1:0] KEY_NUM = DIV_DW'(1) << (RECIP_FRAC_BITS + CAM_SHIFT);
	localparam int PL_W     = PQ_BITS + 3;

	localparam int UOP_COUNT = 26;
	localparam int STEP_W    = $clog2(UOP_COUNT);

	typedef enum logic [REG_W-1:0] {
		REG_SINE_A, REG_COSINE_A, REG_SINE_B, REG_COSINE_B,
		REG_SINE_C, REG_COSINE_C, REG_SCALE, REG_CAM_DIST
	} reg_idx_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_DRAWN = 2'd0, STAT_HIDDEN = 2'd1, STAT_OFF = 2'd2, STAT_READ = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		ST_CLEAR, ST_IDLE, ST_MUL, ST_DRAIN, ST_DIVK, ST_DIVX, ST_DIVY,
		ST_PLACE, ST_LOOK, ST_UPD, ST_RDRQ, ST_RDWB
	} state_t;

	typedef enum logic [1:0] {DIV_KEY, DIV_X, DIV_Y} div_sel_t;

	typedef enum logic [4:0] {
		A_SA, A_CA, A_SB, A_CB, A_SASB, A_CASB,
		A_M00, A_M01, A_M02, A_M10, A_M11, A_M12, A_M20, A_M21, A_M22,
		A_RX, A_RY
	} a_sel_t;

	typedef enum logic [3:0] {
		B_SB, B_CB, B_CC, B_SC, B_ONE, B_PX, B_PY, B_PZ, B_K1X2, B_K1
	} b_sel_t;

	typedef enum logic [3:0] {
		D_SASB, D_CASB, D_M00, D_M01, D_M02, D_M10, D_M11, D_M12,
		D_M20, D_M21, D_M22, D_RX, D_RY, D_RZ, D_NX, D_NY
	} dst_t;

	typedef enum logic [1:0] {OP_LOAD, OP_LNEG, OP_ADD, OP_LCAM} acc_op_t;

	typedef struct packed {
		a_sel_t  a_sel;
		b_sel_t  b_sel;
		logic    sh;
		acc_op_t op;
		dst_t    dst;
	} uop_t;

	typedef struct packed {
		logic signed [TRIG_W-1:0] sine_a;
		logic signed [TRIG_W-1:0] cosine_a;
		logic signed [TRIG_W-1:0] sine_b;
		logic signed [TRIG_W-1:0] cosine_b;
		logic signed [TRIG_W-1:0] sine_c;
		logic signed [TRIG_W-1:0] cosine_c;
		logic [SCALE_W-1:0]       scale;
		logic [CAM_W-1:0]         cam;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		sine_a: 16'sd0, cosine_a: 16'sd16384, sine_b: 16'sd0, cosine_b: 16'sd16384,
		sine_c: 16'sd0, cosine_c: 16'sd16384, scale: 8'd40, cam: 11'd100
	};

	typedef struct packed {
		logic              capture;
		logic              mul_en;
		logic [STEP_W-1:0] step;
		logic              div_start;
		div_sel_t          div_sel;
		div_sel_t          div_wait;
		logic              place;
		logic              off;
		logic              upd;
		logic              rd_ci;
		logic              rd_wb;
		logic              clr_we;
		logic [CELL_W-1:0] clr_addr;
	} ctrl_cmd_t;

	typedef struct packed {
		logic rz_pos;
		logic div_done;
		logic on_screen;
	} dp_stat_t;

	function automatic uop_t mk(input a_sel_t a, input b_sel_t b, input logic sh,
		input acc_op_t op, input dst_t d);
		uop_t u;
		u.a_sel = a;
		u.b_sel = b;
		u.sh    = sh;
		u.op    = op;
		u.dst   = d;
		return u;
	endfunction

	// matrix build, then rotation, then projection numerators
	function automatic uop_t uop_at(input logic [STEP_W-1:0] step);
		uop_t u;
		case (step)
			5'd0:    u = mk(A_SA,   B_SB,   1'b1, OP_LOAD, D_SASB);
			5'd1:    u = mk(A_CA,   B_SB,   1'b1, OP_LOAD, D_CASB);
			5'd2:    u = mk(A_CB,   B_CC,   1'b1, OP_LOAD, D_M00);
			5'd3:    u = mk(A_SASB, B_CC,   1'b1, OP_LOAD, D_M01);
			5'd4:    u = mk(A_CA,   B_SC,   1'b1, OP_ADD,  D_M01);
			5'd5:    u = mk(A_CASB, B_CC,   1'b1, OP_LNEG, D_M02);
			5'd6:    u = mk(A_SA,   B_SC,   1'b1, OP_ADD,  D_M02);
			5'd7:    u = mk(A_CB,   B_SC,   1'b1, OP_LNEG, D_M10);
			5'd8:    u = mk(A_SASB, B_SC,   1'b1, OP_LNEG, D_M11);
			5'd9:    u = mk(A_CA,   B_CC,   1'b1, OP_ADD,  D_M11);
			5'd10:   u = mk(A_CASB, B_SC,   1'b1, OP_LOAD, D_M12);
			5'd11:   u = mk(A_SA,   B_CC,   1'b1, OP_ADD,  D_M12);
			5'd12:   u = mk(A_SB,   B_ONE,  1'b1, OP_LOAD, D_M20);
			5'd13:   u = mk(A_SA,   B_CB,   1'b1, OP_LNEG, D_M21);
			5'd14:   u = mk(A_CA,   B_CB,   1'b1, OP_LOAD, D_M22);
			5'd15:   u = mk(A_M00,  B_PX,   1'b0, OP_LOAD, D_RX);
			5'd16:   u = mk(A_M01,  B_PY,   1'b0, OP_ADD,  D_RX);
			5'd17:   u = mk(A_M02,  B_PZ,   1'b0, OP_ADD,  D_RX);
			5'd18:   u = mk(A_M10,  B_PX,   1'b0, OP_LOAD, D_RY);
			5'd19:   u = mk(A_M11,  B_PY,   1'b0, OP_ADD,  D_RY);
			5'd20:   u = mk(A_M12,  B_PZ,   1'b0, OP_ADD,  D_RY);
			5'd21:   u = mk(A_M20,  B_PX,   1'b0, OP_LCAM, D_RZ);
			5'd22:   u = mk(A_M21,  B_PY,   1'b0, OP_ADD,  D_RZ);
			5'd23:   u = mk(A_M22,  B_PZ,   1'b0, OP_ADD,  D_RZ);
			5'd24:   u = mk(A_RX,   B_K1X2, 1'b0, OP_LOAD, D_NX);
			5'd25:   u = mk(A_RY,   B_K1,   1'b0, OP_LOAD, D_NY);
			default: u = mk(A_SA,   B_SB,   1'b0, OP_LOAD, D_SASB);
		endcase
		return u;
	endfunction

endpackage

// ===== rtl/prpz_div.sv =====
// Restoring divider, one quotient bit per cycle, with up-front overflow check.
module prpz_div import prpz_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [DIV_DW-1:0]   dividend,
	input  logic [DVS_W-1:0]    divisor,
	input  logic [DIV_NW-1:0]   nbits,
	output logic                done,
	output logic                ovf,
	output logic [DIV_QMAX-1:0] quot
);

	logic                busy_q, done_q, ovf_q;
	logic [DIV_NW-1:0]   cnt_q;
	logic [DVS_W-1:0]    rem_q;
	logic [DIV_QMAX-1:0] low_q, quot_q;
	logic [DIV_DW-1:0]   high;
	logic                ovf_c;
	logic [DVS_W+1:0]    trial;

	always_comb begin
		high  = dividend >> nbits;
		ovf_c = high >= DIV_DW'(divisor);
		trial = {1'b0, rem_q, low_q[DIV_QMAX-1]} - (DVS_W+2)'(divisor);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start && !busy_q) begin
				busy_q <= !ovf_c;
				done_q <= ovf_c;
				cnt_q  <= nbits;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_NW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy_q) begin
			ovf_q  <= ovf_c;
			rem_q  <= high[DVS_W-1:0];
			low_q  <= dividend[DIV_QMAX-1:0] << (DIV_NW'(DIV_QMAX) - nbits);
			quot_q <= '0;
		end else if (busy_q) begin
			low_q <= {low_q[DIV_QMAX-2:0], 1'b0};
			if (!trial[DVS_W+1]) begin
				rem_q  <= trial[DVS_W-1:0];
				quot_q <= {quot_q[DIV_QMAX-2:0], 1'b1};
			end else begin
				rem_q  <= {rem_q[DVS_W-2:0], low_q[DIV_QMAX-1]};
				quot_q <= {quot_q[DIV_QMAX-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign ovf  = ovf_q;
	assign quot = quot_q;

endmodule

// ===== rtl/prpz_dp.sv =====
// Datapath: shared multiplier and accumulator, divider, screen placement, stores.
module prpz_dp import prpz_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cfg_t                     cfg,
	input  ctrl_cmd_t                cmd,
	output dp_stat_t                 stat,
	input  logic signed [POS_W-1:0]  pos_x,
	input  logic signed [POS_W-1:0]  pos_y,
	input  logic signed [POS_W-1:0]  pos_z,
	input  logic [GLYPH_W-1:0]       glyph,
	input  logic [CELL_W-1:0]        cell_index,
	output logic                     done,
	output logic [STATUS_W-1:0]      status,
	output logic [CELL_W-1:0]        screen_cell,
	output logic [GLYPH_W-1:0]       cell_glyph
);

	// captured item
	logic signed [POS_W-1:0] px_q, py_q, pz_q;
	logic [GLYPH_W-1:0]      gl_q;
	logic [CELL_W-1:0]       ci_q;

	// working registers
	logic signed [M_W-1:0]   sasb_q, casb_q;
	logic signed [M_W-1:0]   m00_q, m01_q, m02_q, m10_q, m11_q, m12_q, m20_q, m21_q, m22_q;
	logic signed [ROT_W-1:0] rx_q, ry_q, rz_q;
	logic signed [ACC_W-1:0] nx_q, ny_q;

	uop_t                     uop, uop_s1;
	logic                     mv_s1;
	logic signed [OPA_W-1:0]  opa;
	logic signed [OPB_W-1:0]  opb;
	logic signed [PROD_W-1:0] prod_s1, shifted;
	logic signed [ACC_W-1:0]  val, cur, acc, cam_term;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			px_q <= pos_x;
			py_q <= pos_y;
			pz_q <= pos_z;
			gl_q <= glyph;
			ci_q <= cell_index;
		end
	end

	// operand select
	always_comb begin
		uop = uop_at(cmd.step);
		case (uop.a_sel)
			A_SA:    opa = OPA_W'(cfg.sine_a);
			A_CA:    opa = OPA_W'(cfg.cosine_a);
			A_SB:    opa = OPA_W'(cfg.sine_b);
			A_CB:    opa = OPA_W'(cfg.cosine_b);
			A_SASB:  opa = OPA_W'(sasb_q);
			A_CASB:  opa = OPA_W'(casb_q);
			A_M00:   opa = OPA_W'(m00_q);
			A_M01:   opa = OPA_W'(m01_q);
			A_M02:   opa = OPA_W'(m02_q);
			A_M10:   opa = OPA_W'(m10_q);
			A_M11:   opa = OPA_W'(m11_q);
			A_M12:   opa = OPA_W'(m12_q);
			A_M20:   opa = OPA_W'(m20_q);
			A_M21:   opa = OPA_W'(m21_q);
			A_M22:   opa = OPA_W'(m22_q);
			A_RX:    opa = OPA_W'(rx_q);
			A_RY:    opa = OPA_W'(ry_q);
			default: opa = '0;
		endcase
		case (uop.b_sel)
			B_SB:    opb = OPB_W'(cfg.sine_b);
			B_CB:    opb = OPB_W'(cfg.cosine_b);
			B_CC:    opb = OPB_W'(cfg.cosine_c);
			B_SC:    opb = OPB_W'(cfg.sine_c);
			B_ONE:   opb = OPB_W'(ONE_Q14);
			B_PX:    opb = OPB_W'(px_q);
			B_PY:    opb = OPB_W'(py_q);
			B_PZ:    opb = OPB_W'(pz_q);
			B_K1X2:  opb = OPB_W'({cfg.scale, 1'b0});
			B_K1:    opb = OPB_W'(cfg.scale);
			default: opb = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mv_s1 <= 1'b0;
		end else begin
			mv_s1 <= cmd.mul_en;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(opa) * PROD_W'(opb);
		uop_s1  <= uop;
	end

	// accumulate stage
	always_comb begin
		shifted  = uop_s1.sh ? (prod_s1 >>> FRAC_SHIFT) : prod_s1;
		val      = ACC_W'(shifted);
		cam_term = ACC_W'({cfg.cam, {CAM_SHIFT{1'b0}}});
		case (uop_s1.dst)
			D_SASB:  cur = ACC_W'(sasb_q);
			D_CASB:  cur = ACC_W'(casb_q);
			D_M00:   cur = ACC_W'(m00_q);
			D_M01:   cur = ACC_W'(m01_q);
			D_M02:   cur = ACC_W'(m02_q);
			D_M10:   cur = ACC_W'(m10_q);
			D_M11:   cur = ACC_W'(m11_q);
			D_M12:   cur = ACC_W'(m12_q);
			D_M20:   cur = ACC_W'(m20_q);
			D_M21:   cur = ACC_W'(m21_q);
			D_M22:   cur = ACC_W'(m22_q);
			D_RX:    cur = ACC_W'(rx_q);
			D_RY:    cur = ACC_W'(ry_q);
			D_RZ:    cur = ACC_W'(rz_q);
			D_NX:    cur = nx_q;
			D_NY:    cur = ny_q;
			default: cur = '0;
		endcase
		case (uop_s1.op)
			OP_LOAD: acc = val;
			OP_LNEG: acc = -val;
			OP_ADD:  acc = cur + val;
			OP_LCAM: acc = val + cam_term;
			default: acc = val;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			case (uop_s1.dst)
				D_SASB:  sasb_q <= M_W'(acc);
				D_CASB:  casb_q <= M_W'(acc);
				D_M00:   m00_q  <= M_W'(acc);
				D_M01:   m01_q  <= M_W'(acc);
				D_M02:   m02_q  <= M_W'(acc);
				D_M10:   m10_q  <= M_W'(acc);
				D_M11:   m11_q  <= M_W'(acc);
				D_M12:   m12_q  <= M_W'(acc);
				D_M20:   m20_q  <= M_W'(acc);
				D_M21:   m21_q  <= M_W'(acc);
				D_M22:   m22_q  <= M_W'(acc);
				D_RX:    rx_q   <= ROT_W'(acc);
				D_RY:    ry_q   <= ROT_W'(acc);
				D_RZ:    rz_q   <= ROT_W'(acc);
				D_NX:    nx_q   <= acc;
				D_NY:    ny_q   <= acc;
				default: ;
			endcase
		end
	end

	// divisions: depth key, then |nx|/rz, then |ny|/rz
	logic [ACC_W-1:0]    nx_mag, ny_mag;
	logic [DIV_DW-1:0]   dividend;
	logic [DIV_NW-1:0]   nbits;
	logic                div_done, div_ovf;
	logic [DIV_QMAX-1:0] quot;
	logic [DIV_DW-1:0]   quot_ext;
	logic [DEPTH_W-1:0]  key_q;
	logic [PQ_BITS-1:0]  qx_q, qy_q;
	logic                ovfx_q, ovfy_q;

	always_comb begin
		nx_mag = nx_q[ACC_W-1] ? ACC_W'(-nx_q) : ACC_W'(nx_q);
		ny_mag = ny_q[ACC_W-1] ? ACC_W'(-ny_q) : ACC_W'(ny_q);
		case (cmd.div_sel)
			DIV_KEY: begin
				dividend = KEY_NUM;
				nbits    = DIV_NW'(RECIP_FRAC_BITS);
			end
			DIV_X: begin
				dividend = DIV_DW'(nx_mag);
				nbits    = DIV_NW'(PQ_BITS);
			end
			DIV_Y: begin
				dividend = DIV_DW'(ny_mag);
				nbits    = DIV_NW'(PQ_BITS);
			end
			default: begin
				dividend = KEY_NUM;
				nbits    = DIV_NW'(RECIP_FRAC_BITS);
			end
		endcase
		quot_ext = DIV_DW'(quot);
	end

	prpz_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (rz_q[DVS_W-1:0]),
		.nbits    (nbits),
		.done     (div_done),
		.ovf      (div_ovf),
		.quot     (quot)
	);

	always_ff @(posedge clk) begin
		if (div_done) begin
			case (cmd.div_wait)
				DIV_KEY: key_q <= (div_ovf || quot_ext > DIV_DW'(DEPTH_MAX)) ?
					DEPTH_MAX : quot_ext[DEPTH_W-1:0];
				DIV_X: begin
					qx_q   <= quot[PQ_BITS-1:0];
					ovfx_q <= div_ovf;
				end
				DIV_Y: begin
					qy_q   <= quot[PQ_BITS-1:0];
					ovfy_q <= div_ovf;
				end
				default: ;
			endcase
		end
	end

	// screen placement
	logic signed [PL_W-1:0] col, row;
	logic                   on_c, on_q;
	logic [CELL_W-1:0]      hit_c, hit_q;

	always_comb begin
		col   = (nx_q[ACC_W-1] ? -PL_W'({1'b0, qx_q}) : PL_W'({1'b0, qx_q}))
			+ PL_W'(SCREEN_WIDTH / 2);
		row   = (ny_q[ACC_W-1] ? -PL_W'({1'b0, qy_q}) : PL_W'({1'b0, qy_q}))
			+ PL_W'(SCREEN_HEIGHT / 2);
		on_c  = !ovfx_q && !ovfy_q && (col >= 0) && (col < PL_W'(SCREEN_WIDTH))
			&& (row >= 0) && (row < PL_W'(SCREEN_HEIGHT));
		hit_c = CELL_W'(CELL_W'(row) * CELL_W'(SCREEN_WIDTH) + CELL_W'(col));
	end

	always_ff @(posedge clk) begin
		if (cmd.place) begin
			on_q  <= on_c;
			hit_q <= hit_c;
		end
	end

	// glyph and depth stores
	logic [GLYPH_W-1:0] glyph_mem [CELLS];
	logic [DEPTH_W-1:0] depth_mem [CELLS];
	logic [GLYPH_W-1:0] gl_rd_q;
	logic [DEPTH_W-1:0] dp_rd_q;
	logic               ci_ok, we, wins;
	logic [CELL_W-1:0]  rd_addr, wa;
	logic [GLYPH_W-1:0] wg;
	logic [DEPTH_W-1:0] wd;

	always_comb begin
		ci_ok   = ci_q < CELL_W'(CELLS);
		rd_addr = cmd.rd_ci ? (ci_ok ? ci_q : '0) : hit_q;
		wins    = key_q > dp_rd_q;
		we      = 1'b0;
		wa      = cmd.clr_addr;
		wg      = GLYPH_W'(BACKGROUND_CHAR);
		wd      = '0;
		if (cmd.clr_we) begin
			we = 1'b1;
		end else if (cmd.upd && wins) begin
			we = 1'b1;
			wa = hit_q;
			wg = gl_q;
			wd = key_q;
		end else if (cmd.rd_wb && ci_ok) begin
			we = 1'b1;
			wa = ci_q;
		end
	end

	always_ff @(posedge clk) begin
		gl_rd_q <= glyph_mem[rd_addr];
		dp_rd_q <= depth_mem[rd_addr];
		if (we) begin
			glyph_mem[wa] <= wg;
			depth_mem[wa] <= wd;
		end
	end

	// result register
	logic               done_q;
	status_t            res_status_q;
	logic [CELL_W-1:0]  res_cell_q;
	logic [GLYPH_W-1:0] res_glyph_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.off || cmd.upd || cmd.rd_wb;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.off) begin
			res_status_q <= STAT_OFF;
			res_cell_q   <= '0;
			res_glyph_q  <= '0;
		end else if (cmd.upd) begin
			res_status_q <= wins ? STAT_DRAWN : STAT_HIDDEN;
			res_cell_q   <= hit_q;
			res_glyph_q  <= '0;
		end else if (cmd.rd_wb) begin
			res_status_q <= STAT_READ;
			res_cell_q   <= ci_q;
			res_glyph_q  <= ci_ok ? gl_rd_q : '0;
		end
	end

	assign stat.rz_pos    = rz_q > 0;
	assign stat.div_done  = div_done;
	assign stat.on_screen = on_q;

	assign done        = done_q;
	assign status      = res_status_q;
	assign screen_cell = res_cell_q;
	assign cell_glyph  = res_glyph_q;

endmodule

// ===== rtl/prpz_ctrl.sv =====
// Controller: sequences store clearing, multiply steps, divisions and store access.
module prpz_ctrl import prpz_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      mode,
	input  dp_stat_t  stat,
	output logic      busy,
	output ctrl_cmd_t cmd
);

	state_t            state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic [CELL_W-1:0] clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			step_q  <= '0;
			clr_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (state_q == ST_MUL) begin
				step_q <= step_q + 1'b1;
			end else begin
				step_q <= '0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: if (clr_q == CELL_W'(CELLS - 1)) state_d = ST_IDLE;
			ST_IDLE:  if (start) state_d = mode ? ST_RDRQ : ST_MUL;
			ST_MUL:   if (step_q == STEP_W'(UOP_COUNT - 1)) state_d = ST_DRAIN;
			ST_DRAIN: state_d = stat.rz_pos ? ST_DIVK : ST_IDLE;
			ST_DIVK:  if (stat.div_done) state_d = ST_DIVX;
			ST_DIVX:  if (stat.div_done) state_d = ST_DIVY;
			ST_DIVY:  if (stat.div_done) state_d = ST_PLACE;
			ST_PLACE: state_d = ST_LOOK;
			ST_LOOK:  state_d = stat.on_screen ? ST_UPD : ST_IDLE;
			ST_UPD:   state_d = ST_IDLE;
			ST_RDRQ:  state_d = ST_RDWB;
			ST_RDWB:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd          = '0;
		cmd.step     = step_q;
		cmd.clr_addr = clr_q;
		cmd.div_sel  = DIV_KEY;
		cmd.div_wait = DIV_KEY;
		case (state_q)
			ST_CLEAR: cmd.clr_we  = 1'b1;
			ST_IDLE:  cmd.capture = start;
			ST_MUL:   cmd.mul_en  = 1'b1;
			ST_DRAIN: begin
				cmd.div_start = stat.rz_pos;
				cmd.off       = !stat.rz_pos;
			end
			ST_DIVK: begin
				cmd.div_start = stat.div_done;
				cmd.div_sel   = DIV_X;
			end
			ST_DIVX: begin
				cmd.div_wait  = DIV_X;
				cmd.div_start = stat.div_done;
				cmd.div_sel   = DIV_Y;
			end
			ST_DIVY:  cmd.div_wait = DIV_Y;
			ST_PLACE: cmd.place    = 1'b1;
			ST_LOOK:  cmd.off      = !stat.on_screen;
			ST_UPD:   cmd.upd      = 1'b1;
			ST_RDRQ:  cmd.rd_ci    = 1'b1;
			ST_RDWB:  cmd.rd_wb    = 1'b1;
			default:  ;
		endcase
	end

	assign busy = state_q != ST_IDLE;

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MUL) |-> (step_q < STEP_W'(UOP_COUNT)))
		else $error("multiply step past end of table");

	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |=> (state_q == ST_CLEAR || state_q == ST_IDLE))
		else $error("clearing pass left early");

	a_one_action: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.mul_en, cmd.div_start, cmd.clr_we, cmd.upd, cmd.rd_wb, cmd.capture}))
		else $error("conflicting datapath commands");

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.off, cmd.upd, cmd.rd_wb}))
		else $error("two results in one cycle");

endmodule

// ===== rtl/point_rotate_project_zbuffer.sv =====
// Top level: APB register block, controller and datapath of the rotate/project/z-buffer block.
// Plot item, from the accepting edge to done: 26 shared-multiplier steps, a drain state,
//   three divisions on one bit-serial divider (24, 8 and 8 quotient bits, each followed by
//   a done strobe), placement, store lookup and update. A divide overflow skips its
//   quotient bits; an off-screen point ends after lookup, one behind the camera after drain.
// Read item: request, then write-back. One item at a time; busy holds start off until the
//   result is out, and done pulses one cycle per result: the receiver cannot stall. Reset
//   clears the stores one cell a cycle; busy stays high until all 7040 cells are cleared.
module point_rotate_project_zbuffer import prpz_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration port
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// item in
	input  logic                    start,
	output logic                    busy,
	input  logic                    mode,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	input  logic signed [POS_W-1:0] pos_z,
	input  logic [GLYPH_W-1:0]      glyph,
	input  logic [CELL_W-1:0]       cell_index,
	// result out
	output logic                    done,
	output logic [STATUS_W-1:0]     status,
	output logic [CELL_W-1:0]       screen_cell,
	output logic [GLYPH_W-1:0]      cell_glyph
);

	cfg_t      cfg_q;
	reg_idx_t  ridx;
	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	assign ridx   = reg_idx_t'(paddr[PADDR_W-1:2]);
	assign pready = 1'b1;

	// register writes land on the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (psel && penable && pwrite) begin
			case (ridx)
				REG_SINE_A:   cfg_q.sine_a   <= pwdata[TRIG_W-1:0];
				REG_COSINE_A: cfg_q.cosine_a <= pwdata[TRIG_W-1:0];
				REG_SINE_B:   cfg_q.sine_b   <= pwdata[TRIG_W-1:0];
				REG_COSINE_B: cfg_q.cosine_b <= pwdata[TRIG_W-1:0];
				REG_SINE_C:   cfg_q.sine_c   <= pwdata[TRIG_W-1:0];
				REG_COSINE_C: cfg_q.cosine_c <= pwdata[TRIG_W-1:0];
				REG_SCALE:    cfg_q.scale    <= pwdata[SCALE_W-1:0];
				REG_CAM_DIST: cfg_q.cam      <= pwdata[CAM_W-1:0];
				default:      ;
			endcase
		end
	end

	// read back the raw register bits
	always_comb begin
		case (ridx)
			REG_SINE_A:   prdata = 32'({cfg_q.sine_a});
			REG_COSINE_A: prdata = 32'({cfg_q.cosine_a});
			REG_SINE_B:   prdata = 32'({cfg_q.sine_b});
			REG_COSINE_B: prdata = 32'({cfg_q.cosine_b});
			REG_SINE_C:   prdata = 32'({cfg_q.sine_c});
			REG_COSINE_C: prdata = 32'({cfg_q.cosine_c});
			REG_SCALE:    prdata = 32'(cfg_q.scale);
			REG_CAM_DIST: prdata = 32'(cfg_q.cam);
			default:      prdata = '0;
		endcase
	end

	// sequencing
	prpz_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (mode),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// arithmetic and stores
	prpz_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.cmd         (cmd),
		.stat        (stat),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.pos_z       (pos_z),
		.glyph       (glyph),
		.cell_index  (cell_index),
		.done        (done),
		.status      (status),
		.screen_cell (screen_cell),
		.cell_glyph  (cell_glyph)
	);

endmodule
